FILE: hdl/msmp_pkg.sv
// Shared constants, types and result codes for the minimum sum of segment
// maxima partition block. No dependencies.
`default_nettype none

package msmp_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_JOBS_DEF  = 256;
  localparam int MAX_DAYS_DEF  = 16;
  localparam int DIFF_BITS_DEF = 10;

  // Fixed field widths of the stream and configuration ports.
  localparam int JOB_W     = 10;
  localparam int TOTAL_W   = 18;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 5;
  localparam int S_DATA_W  = 16;
  localparam int M_DATA_W  = 24;
  localparam int TOTAL_MAX = 262143;

  localparam logic [CFG_W-1:0] DAY_COUNT_RST = CFG_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FEW_JOBS = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Control tag of one compare-add step, aligned with the memory read data.
  typedef struct packed {
    logic valid;      // a step is in the unit this cycle
    logic first;      // first step of a column entry: restart max and best
    logic last;       // last step of a column entry: write the entry
    logic prev_zero;  // previous-column value is the zero base case
    logic prev_inf;   // previous-column value is infinite
    logic rd_bank;    // column bank that holds the previous day
    logic final_step; // last step of the whole fill
  } step_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/msmp_ram.sv
// Simple dual-port memory: one write port and one read port with registered
// read data. Used for the job store and both day columns. No dependencies.
`default_nettype none

module msmp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 10,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/msmp_step_unit.sv
// Shared compare-add unit: running segment maximum, saturating add of the
// previous-day cost and running minimum. Depends on msmp_pkg.
`default_nettype none

module msmp_step_unit import msmp_pkg::*; #(
  parameter int SW = 10,
  parameter int CW = 20
) (
  input  wire logic          clk_i,
  input  wire step_ctrl_t    ctrl_i,
  input  wire logic [SW-1:0] job_i,
  input  wire logic [CW-1:0] prev_i,
  output logic      [CW-1:0] best_o,
  output logic               wr_en_o,
  output logic               done_o
);

  localparam logic [CW-1:0] COST_INF = '1;

  logic [SW-1:0] seg_q, seg_d;
  logic [CW-1:0] best_q;
  logic [CW-1:0] prev_sel;
  logic [CW-1:0] cost;

  always_comb begin
    seg_d = (ctrl_i.first || (job_i > seg_q)) ? job_i : seg_q;
    if (ctrl_i.prev_zero) begin
      prev_sel = '0;
    end else if (ctrl_i.prev_inf) begin
      prev_sel = COST_INF;
    end else begin
      prev_sel = prev_i;
    end
    // Finite sums stay below the top half of the range, so only an
    // infinite operand can saturate.
    cost   = (prev_sel == COST_INF) ? COST_INF : prev_sel + CW'(seg_d);
    best_o = (ctrl_i.first || (cost < best_q)) ? cost : best_q;
  end

  assign wr_en_o = ctrl_i.valid && ctrl_i.last;
  assign done_o  = ctrl_i.valid && ctrl_i.final_step;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      seg_q  <= seg_d;
      best_q <= best_o;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/msmp_fill_seq.sv
// Table fill sequencer: walks day k, column entry i and split point j, issues
// memory addresses and a registered step tag aligned with the read data. Depends on msmp_pkg.
`default_nettype none

module msmp_fill_seq import msmp_pkg::*; #(
  parameter int MAX_JOBS = 256,
  parameter int MAX_DAYS = 16,
  localparam int JW      = $clog2(MAX_JOBS + 1),
  localparam int DW      = $clog2(MAX_DAYS + 1),
  localparam int AW      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [JW-1:0] n_i,
  input  wire logic [DW-1:0] days_i,
  output step_ctrl_t         ctrl_o,
  output logic      [AW-1:0] job_addr_o,
  output logic      [AW-1:0] col_addr_o,
  output logic      [AW-1:0] wr_addr_o
);

  logic          run_q;
  logic [JW-1:0] n_q, i_q, j_q;
  logic [DW-1:0] days_q, k_q;
  logic          j_one, i_end, k_end;
  step_ctrl_t    issue;

  assign j_one = (j_q == JW'(1));
  assign i_end = (i_q == n_q);
  assign k_end = (k_q == days_q);

  always_comb begin
    issue.valid      = run_q;
    issue.first      = (j_q == i_q);
    issue.last       = j_one;
    issue.prev_zero  = j_one && (k_q == DW'(1));
    issue.prev_inf   = (k_q == DW'(1)) != j_one;
    issue.rd_bank    = ~k_q[0];
    issue.final_step = j_one && i_end && k_end;
  end

  // Job j-1 and previous-column entry j-1 (stored at j-2; entry 0 is implicit).
  assign job_addr_o = AW'(j_q - JW'(1));
  assign col_addr_o = AW'(j_q - JW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      ctrl_o <= '0;
    end else begin
      ctrl_o <= issue;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && j_one && i_end && k_end) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_o <= AW'(i_q - JW'(1));
    if (start_i) begin
      n_q    <= n_i;
      days_q <= days_i;
      i_q    <= JW'(1);
      j_q    <= JW'(1);
      k_q    <= DW'(1);
    end else if (run_q) begin
      if (!j_one) begin
        j_q <= j_q - JW'(1);
      end else if (!i_end) begin
        i_q <= i_q + JW'(1);
        j_q <= i_q + JW'(1);
      end else if (!k_end) begin
        k_q <= k_q + DW'(1);
        i_q <= JW'(1);
        j_q <= JW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/min_sum_of_max_partition.sv
// Minimum sum of segment maxima partition: top level with job loading,
// result register and the table fill built from msmp_fill_seq,
// msmp_step_unit and three msmp_ram instances. Depends on msmp_pkg.
// Loading: one job beat per cycle; a beat that is not marked last is stored,
// while the store has room, in the cycle it is accepted, and s_axis_tready
// stays high meanwhile. A last beat with a valid sequence starts the fill,
// which runs every split point of every column entry of every day through
// the single compare-add unit; input is held off until it is done.
// An overflow or too-few-jobs result is ready in the cycle after the last beat.
// Reset clears control state and sets day_count to 1; memories are not cleared.
`default_nettype none

module min_sum_of_max_partition import msmp_pkg::*; #(
  parameter int MAX_JOBS  = MAX_JOBS_DEF,
  parameter int MAX_DAYS  = MAX_DAYS_DEF,
  parameter int DIFF_BITS = DIFF_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration: day_count, written whenever cfg_we_i is high.
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  // Job stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // [9:0] job_difficulty, rest zero
  input  wire logic                s_axis_tlast,  // last_job
  // Result stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [M_DATA_W-1:0]      m_axis_tdata,  // [17:0] min_total, rest zero
  output logic [STATUS_W-1:0]      m_axis_tuser   // [1:0] status
);

  // Stored difficulty width; the job field is only JOB_W bits wide.
  localparam int SW = (DIFF_BITS < JOB_W) ? DIFF_BITS : JOB_W;
  localparam int JW = $clog2(MAX_JOBS + 1);
  localparam int DW = $clog2(MAX_DAYS + 1);
  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  // Cost width: every finite sum fits below the top half, all ones is infinity.
  localparam int CW = JW + SW + 1;

  typedef enum logic {
    S_LOAD,
    S_FILL
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    day_cfg_q;
  logic [JW-1:0]       cnt_q;
  logic                ovf_q;
  logic                out_valid_q;
  logic [TOTAL_W-1:0]  out_total_q;
  status_e             out_status_q;

  logic                s_acc, m_acc;
  logic                store_full;
  logic                ovf_now;
  logic [JW-1:0]       cnt_now;
  logic [DW-1:0]       days_eff;
  logic                few_jobs;
  logic                fill_start;

  step_ctrl_t          ctrl;
  logic [AW-1:0]       job_raddr, col_raddr, col_waddr;
  logic [SW-1:0]       job_rdata;
  logic [CW-1:0]       col0_rdata, col1_rdata, prev_cost;
  logic [CW-1:0]       best;
  logic                col_we, fill_done;
  logic [TOTAL_W-1:0]  total_clamped;

  // A last beat waits while an earlier result still sits in the output
  // register; ordinary job beats keep flowing.
  assign s_axis_tready = (state_q == S_LOAD) && !(out_valid_q && s_axis_tlast);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;

  assign store_full = (32'(cnt_q) >= MAX_JOBS);
  assign ovf_now    = ovf_q || store_full;
  assign cnt_now    = store_full ? cnt_q : cnt_q + JW'(1);

  // A day count of zero acts as one; anything above the capacity saturates.
  always_comb begin
    if (day_cfg_q == '0) begin
      days_eff = DW'(1);
    end else if (32'(day_cfg_q) > MAX_DAYS) begin
      days_eff = DW'(MAX_DAYS);
    end else begin
      days_eff = DW'(day_cfg_q);
    end
  end

  assign few_jobs   = (32'(cnt_now) < 32'(days_eff));
  assign fill_start = s_acc && s_axis_tlast && !ovf_now && !few_jobs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_cfg_q <= DAY_COUNT_RST;
    end else if (cfg_we_i) begin
      day_cfg_q <= cfg_wdata_i;
    end
  end

  // Sequencer state, job count, overflow flag and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_total_q  <= '0;
      out_status_q <= ST_OK;
    end else begin
      if (m_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (s_acc) begin
            if (s_axis_tlast) begin
              cnt_q <= '0;
              ovf_q <= 1'b0;
              if (ovf_now) begin
                out_valid_q  <= 1'b1;
                out_total_q  <= '0;
                out_status_q <= ST_OVERFLOW;
              end else if (few_jobs) begin
                out_valid_q  <= 1'b1;
                out_total_q  <= '0;
                out_status_q <= ST_FEW_JOBS;
              end else begin
                state_q <= S_FILL;
              end
            end else begin
              cnt_q <= cnt_now;
              ovf_q <= ovf_now;
            end
          end
        end
        S_FILL: begin
          if (fill_done) begin
            out_valid_q  <= 1'b1;
            out_total_q  <= total_clamped;
            out_status_q <= ST_OK;
            state_q      <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign total_clamped = (32'(best) > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(best);

  // Job store: written while loading, read by the fill sequencer.
  msmp_ram #(
    .DEPTH (MAX_JOBS),
    .WIDTH (SW)
  ) u_job_store (
    .clk_i   (clk_i),
    .we_i    (s_acc && !store_full),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata[SW-1:0]),
    .raddr_i (job_raddr),
    .rdata_o (job_rdata)
  );

  msmp_fill_seq #(
    .MAX_JOBS (MAX_JOBS),
    .MAX_DAYS (MAX_DAYS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fill_start),
    .n_i        (cnt_now),
    .days_i     (days_eff),
    .ctrl_o     (ctrl),
    .job_addr_o (job_raddr),
    .col_addr_o (col_raddr),
    .wr_addr_o  (col_waddr)
  );

  // Two day columns in ping-pong: one holds the previous day while the
  // other takes the current one. Column entry i lives at address i-1.
  msmp_ram #(
    .DEPTH (MAX_JOBS),
    .WIDTH (CW)
  ) u_col0 (
    .clk_i   (clk_i),
    .we_i    (col_we && ctrl.rd_bank),
    .waddr_i (col_waddr),
    .wdata_i (best),
    .raddr_i (col_raddr),
    .rdata_o (col0_rdata)
  );

  msmp_ram #(
    .DEPTH (MAX_JOBS),
    .WIDTH (CW)
  ) u_col1 (
    .clk_i   (clk_i),
    .we_i    (col_we && !ctrl.rd_bank),
    .waddr_i (col_waddr),
    .wdata_i (best),
    .raddr_i (col_raddr),
    .rdata_o (col1_rdata)
  );

  assign prev_cost = ctrl.rd_bank ? col1_rdata : col0_rdata;

  msmp_step_unit #(
    .SW (SW),
    .CW (CW)
  ) u_step (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .job_i   (job_rdata),
    .prev_i  (prev_cost),
    .best_o  (best),
    .wr_en_o (col_we),
    .done_o  (fill_done)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'(out_total_q);
  assign m_axis_tuser  = out_status_q;

  // The column memories are only written while a fill runs.
  a_col_write_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_we |-> (state_q == S_FILL))
    else $error("column write outside a fill");

  // A finished fill always finds the result register empty.
  a_done_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done |-> ((state_q == S_FILL) && !out_valid_q))
    else $error("fill finished while a result was pending");

  // Overflow is only flagged once the store is full.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (32'(cnt_q) == MAX_JOBS))
    else $error("overflow flag set with room in the store");

  // A fill is never started with an empty or overfull job count.
  a_start_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_start |-> ((cnt_now != '0) && (32'(cnt_now) <= MAX_JOBS)))
    else $error("fill started with a bad job count");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for min_sum_of_max_partition: streams job beats, predicts each result
// with its own partition table fill unless the stimulus fixes it, and checks the
// result stream beat by beat. Depends on msmp_pkg and the min_sum_of_max_partition RTL.
module tb_top;
  import msmp_pkg::*;

  localparam int     NJOBS        = MAX_JOBS_DEF;
  localparam int     NDAYS        = MAX_DAYS_DEF;
  localparam longint COST_INF     = 64'hFFFF_FFFF_FFFF;
  localparam int     IDLE_PCT     = 38;
  localparam int     RANDOM_BEATS = 140;
  localparam int     NROWS        = 20;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    status_e            status;
  } day_result_t;

  // Expected result fixed by the stimulus, or left to the predictor.
  typedef struct packed {
    logic        known;
    day_result_t res;
  } result_tag_t;

  typedef struct {
    bit                 wr_days;
    logic [CFG_W-1:0]   days;
    logic [JOB_W-1:0]   job;
    int                 reps;
    bit                 last;
    bit                 known;
    logic [TOTAL_W-1:0] exp_total;
    status_e            exp_status;
  } seq_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  // Predictor state.
  logic [JOB_W-1:0] job_mem [NJOBS];
  int               job_cnt        = 0;
  bit               store_overflow = 1'b0;
  logic [CFG_W-1:0] day_reg        = DAY_COUNT_RST;

  day_result_t expected_totals_q [$];
  result_tag_t typed_results_q [$];

  int err_cnt      = 0;
  int beats_in     = 0;
  int results_seen = 0;
  int n_ok         = 0;
  int n_few        = 0;
  int n_ovf        = 0;
  bit no_idle;

  // Directed sequences: a row sends reps beats of one job value, the final one marked
  // last when the row says so.
  seq_row_t dir_rows [NROWS] = '{
    // one day after reset: single hardest and easiest job
    '{0, 5'd0,  10'd1023, 1,   1, 1, 18'd1023, ST_OK},
    '{0, 5'd0,  10'd0,    1,   1, 1, 18'd0,    ST_OK},
    // descending run split over two days
    '{1, 5'd2,  10'd6,    1,   0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd5,    1,   0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd4,    1,   0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd3,    1,   0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd2,    1,   0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd1,    1,   1, 0, 18'd0,    ST_OK},
    // a day count of zero behaves as one day
    '{1, 5'd0,  10'd9,    1,   0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd300,  1,   1, 1, 18'd300,  ST_OK},
    // maximum day count with too few jobs
    '{1, 5'd16, 10'd1,    3,   1, 1, 18'd0,    ST_FEW_JOBS},
    // day count above the maximum saturates
    '{1, 5'd31, 10'd1023, 16,  1, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd0,    15,  1, 1, 18'd0,    ST_FEW_JOBS},
    // completely full job store
    '{1, 5'd2,  10'd1023, 256, 1, 0, 18'd0,    ST_OK},
    // store overflow, with the dropped job carrying the last mark
    '{0, 5'd0,  10'd512,  256, 0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd3,    1,   1, 1, 18'd0,    ST_OVERFLOW},
    // overflow with several dropped jobs
    '{1, 5'd1,  10'd1023, 256, 0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd0,    5,   0, 0, 18'd0,    ST_OK},
    '{0, 5'd0,  10'd0,    1,   1, 1, 18'd0,    ST_OVERFLOW},
    // counters start over after an overflow
    '{1, 5'd5,  10'd7,    4,   1, 1, 18'd0,    ST_FEW_JOBS}
  };

  min_sum_of_max_partition dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int eff_days(input logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > NDAYS) return NDAYS;
    return int'(d);
  endfunction

  // Smallest sum of segment maxima over the stored jobs, two day columns at a time.
  function automatic logic [TOTAL_W-1:0] min_seg_total(input int n, input int days);
    longint prev_col [NJOBS+1];
    longint cur_col [NJOBS+1];
    longint best;
    longint seg_max;
    longint cost;
    int     i;
    int     j;
    int     k;
    prev_col[0] = 0;
    for (i = 1; i <= n; i++) prev_col[i] = COST_INF;
    for (k = 1; k <= days; k++) begin
      cur_col[0] = COST_INF;
      for (i = 1; i <= n; i++) begin
        best    = COST_INF;
        seg_max = 0;
        for (j = i; j > 0; j--) begin
          if (job_mem[j-1] > seg_max) seg_max = job_mem[j-1];
          cost = prev_col[j-1] + seg_max;
          if (cost >= COST_INF) cost = COST_INF;
          if (cost < best) best = cost;
        end
        cur_col[i] = best;
      end
      prev_col = cur_col;
    end
    if (prev_col[n] > TOTAL_MAX) return TOTAL_W'(TOTAL_MAX);
    return TOTAL_W'(prev_col[n]);
  endfunction

  function automatic void take_job(input logic [JOB_W-1:0] job, input bit last);
    int          days;
    day_result_t res;
    result_tag_t tag;
    if (job_cnt < NJOBS) begin
      job_mem[job_cnt] = job;
      job_cnt++;
    end else begin
      store_overflow = 1'b1;
    end
    if (last) begin
      days      = eff_days(day_reg);
      res.total = '0;
      if (store_overflow) begin
        res.status = ST_OVERFLOW;
      end else if (job_cnt < days) begin
        res.status = ST_FEW_JOBS;
      end else begin
        res.status = ST_OK;
        res.total  = min_seg_total(job_cnt, days);
      end
      if (typed_results_q.size() != 0) begin
        tag = typed_results_q.pop_front();
        if (tag.known) res = tag.res;
      end
      expected_totals_q.push_back(res);
      job_cnt        = 0;
      store_overflow = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      beats_in++;
      take_job(s_axis_tdata[JOB_W-1:0], s_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    day_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_totals_q.size() == 0) begin
        err_cnt++;
        $error("unexpected result beat: min_total %0d status %0d",
               m_axis_tdata[TOTAL_W-1:0], m_axis_tuser);
      end else begin
        want = expected_totals_q.pop_front();
        results_seen++;
        if (m_axis_tdata[TOTAL_W-1:0] !== want.total) begin
          err_cnt++;
          $error("min_total: expected %0d, got %0d", want.total, m_axis_tdata[TOTAL_W-1:0]);
        end
        if (m_axis_tuser !== want.status) begin
          err_cnt++;
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
        end
        if (m_axis_tdata[M_DATA_W-1:TOTAL_W] !== '0) begin
          err_cnt++;
          $error("tdata padding: expected 0, got %0h", m_axis_tdata[M_DATA_W-1:TOTAL_W]);
        end
        case (want.status)
          ST_OK:       n_ok++;
          ST_FEW_JOBS: n_few++;
          default:     n_ovf++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_job(input logic [JOB_W-1:0] job, input bit last);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_DATA_W-JOB_W){1'b0}}, job};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold the job stream until every pending result has been taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_totals_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_days(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    day_reg      = value;
  endtask

  initial begin
    int          rand_beats;
    int          seq_no;
    int          len;
    int          days;
    result_tag_t tag;
    logic [JOB_W-1:0] job;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    no_idle       <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NROWS; r++) begin
      if (dir_rows[r].wr_days) set_days(dir_rows[r].days);
      if (dir_rows[r].last) begin
        tag.known      = dir_rows[r].known;
        tag.res.total  = dir_rows[r].exp_total;
        tag.res.status = dir_rows[r].exp_status;
        typed_results_q.push_back(tag);
      end
      for (int b = 0; b < dir_rows[r].reps; b++) begin
        send_job(dir_rows[r].job, dir_rows[r].last && (b == dir_rows[r].reps - 1));
      end
    end

    // Random sequences: mostly long enough for the day count, some cut short.
    rand_beats = 0;
    seq_no     = 0;
    tag        = '0;
    while (rand_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 3) == 0) set_days(CFG_W'($urandom_range(0, 31)));
        else set_days(CFG_W'($urandom_range(1, 6)));
      end else if ($urandom_range(0, 4) == 0) begin
        wait_drained();
      end
      no_idle <= (seq_no >= 8 && seq_no < 14);
      days = eff_days(day_reg);
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, days);
      else len = $urandom_range(days, days + 8);
      typed_results_q.push_back(tag);
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(0, 2) == 0) job = JOB_W'($urandom_range(0, 15));
        else job = JOB_W'($urandom_range(0, 1023));
        send_job(job, b == len - 1);
      end
      rand_beats += len;
      seq_no++;
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    $display("Streamed %0d job beats and checked %0d results: %0d ok, %0d too few jobs, %0d overflow.",
             beats_in, results_seen, n_ok, n_few, n_ovf);
    $display("Day counts 0, 1, 16 and 31 were used, along with a full job store and overflow.");
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
